FILE: sv/inactivity_power_state_manager_top_defines.svh
// Assertion macros shared by the RTL modules.
`ifndef INACTIVITY_POWER_STATE_MANAGER_TOP_DEFINES_SVH
`define INACTIVITY_POWER_STATE_MANAGER_TOP_DEFINES_SVH

// Check a property on an explicit clock and active-low reset.
`define IPSM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on clk_i and rst_ni.
`define IPSM_ASSERT(label, prop, msg) \
  `IPSM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

FILE: sv/ipsm_pkg.sv
`default_nettype none

package ipsm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned SyncW   = 16;
  localparam int unsigned CodeW   = 3;
  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [5:0] {
    ST_BLOCKED   = 6'b000001,
    ST_RECENT    = 6'b000010,
    ST_DIM       = 6'b000100,
    ST_SLEEP     = 6'b001000,
    ST_DIMSLEEP  = 6'b010000,
    ST_SHUTDOWN  = 6'b100000
  } state_e;

  typedef enum logic [CodeW-1:0] {
    CODE_BLOCKED  = 3'd0,
    CODE_RECENT   = 3'd1,
    CODE_DIM      = 3'd2,
    CODE_SLEEP    = 3'd3,
    CODE_DIMSLEEP = 3'd4,
    CODE_SHUTDOWN = 3'd5
  } state_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_CPU        = 3'd0,
    CFG_LIGHT_SLEEP     = 3'd1,
    CFG_FULL_BRIGHTNESS = 3'd2,
    CFG_SHUTDOWN        = 3'd3,
    CFG_SYNC_WINDOW     = 3'd4,
    CFG_SHUTDOWN_EN     = 3'd5,
    CFG_LIGHT_SLEEP_EN  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [TimeW-1:0] full_cpu_ms;
    logic [TimeW-1:0] light_sleep_ms;
    logic [TimeW-1:0] full_brightness_ms;
    logic [TimeW-1:0] shutdown_ms;
    logic [SyncW-1:0] sync_window_ms;
    logic             shutdown_enable;
    logic             light_sleep_enable;
  } cfg_t;

  typedef struct packed {
    logic             func;
    logic             core;
    logic [TimeW-1:0] now_ms;
    logic             save_blocked;
    logic             audio_busy;
  } item_t;

  typedef struct packed {
    state_code_e power_state;
    logic        state_moved;
    logic        brightness_full;
    logic        cpu_max;
    logic        init_pulse;
    logic        shutdown_request;
    logic        sleep_request;
  } result_t;

  function automatic state_code_e encode_state(state_e st);
    state_code_e code;
    code = CODE_RECENT;
    unique case (st)
      ST_BLOCKED:  code = CODE_BLOCKED;
      ST_RECENT:   code = CODE_RECENT;
      ST_DIM:      code = CODE_DIM;
      ST_SLEEP:    code = CODE_SLEEP;
      ST_DIMSLEEP: code = CODE_DIMSLEEP;
      ST_SHUTDOWN: code = CODE_SHUTDOWN;
      default:     code = CODE_RECENT;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: sv/ipsm_cfg.sv
`default_nettype none

module ipsm_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          wr_en_i,
  input  wire logic [ipsm_pkg::CfgIdxW-1:0] wr_index_i,
  input  wire logic [ipsm_pkg::TimeW-1:0]   wr_data_i,
  output ipsm_pkg::cfg_t                     cfg_o
);

  ipsm_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (ipsm_pkg::cfg_reg_e'(wr_index_i))
        ipsm_pkg::CFG_FULL_CPU:        cfg_d.full_cpu_ms        = wr_data_i;
        ipsm_pkg::CFG_LIGHT_SLEEP:     cfg_d.light_sleep_ms     = wr_data_i;
        ipsm_pkg::CFG_FULL_BRIGHTNESS: cfg_d.full_brightness_ms = wr_data_i;
        ipsm_pkg::CFG_SHUTDOWN:        cfg_d.shutdown_ms        = wr_data_i;
        ipsm_pkg::CFG_SYNC_WINDOW:
          cfg_d.sync_window_ms = wr_data_i[ipsm_pkg::SyncW-1:0];
        ipsm_pkg::CFG_SHUTDOWN_EN:     cfg_d.shutdown_enable    = wr_data_i[0];
        ipsm_pkg::CFG_LIGHT_SLEEP_EN:  cfg_d.light_sleep_enable = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.full_cpu_ms        <= 32'd10000;
      cfg_q.light_sleep_ms     <= 32'd30000;
      cfg_q.full_brightness_ms <= 32'd60000;
      cfg_q.shutdown_ms        <= 32'd300000;
      cfg_q.sync_window_ms     <= 16'd20;
      cfg_q.shutdown_enable    <= 1'b0;
      cfg_q.light_sleep_enable <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: sv/ipsm_core.sv
`default_nettype none

`include "inactivity_power_state_manager_top_defines.svh"

module ipsm_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 adv_i,
  input  wire ipsm_pkg::item_t      item_i,
  input  wire ipsm_pkg::cfg_t       cfg_i,
  output ipsm_pkg::result_t         res_o
);

  ipsm_pkg::state_e             state_q, state_d;
  logic [ipsm_pkg::TimeW-1:0]   last_q, last_d;
  logic [ipsm_pkg::TimeW-1:0]   poll_q [2];
  logic [ipsm_pkg::TimeW-1:0]   poll_d [2];
  logic [1:0]                   mark_q, mark_d;
  logic                         init_q, latch_q, latch_d;

  logic                         first;
  logic                         sleep_blk;
  logic [ipsm_pkg::TimeW-1:0]   last_eff, idle, age;
  logic [ipsm_pkg::TimeW-1:0]   poll_eff [2];
  ipsm_pkg::state_e             target;
  logic                         changed, shut, sleep_req, sleep_ok, other_mark;
  logic                         other;
  ipsm_pkg::state_code_e        code;

  assign first     = !init_q;
  assign sleep_blk = item_i.save_blocked | item_i.audio_busy;
  assign other     = ~item_i.core;
  assign last_eff  = first ? item_i.now_ms : last_q;
  assign poll_eff[0] = first ? item_i.now_ms : poll_q[0];
  assign poll_eff[1] = first ? item_i.now_ms : poll_q[1];
  assign idle      = item_i.now_ms - last_eff;
  assign age       = item_i.now_ms - poll_eff[other];

  always_comb begin
    priority if (item_i.save_blocked) begin
      target = ipsm_pkg::ST_BLOCKED;
    end else if (idle >= cfg_i.shutdown_ms) begin
      target = (cfg_i.shutdown_enable && !sleep_blk) ? ipsm_pkg::ST_SHUTDOWN
                                                     : ipsm_pkg::ST_DIMSLEEP;
    end else if (idle >= cfg_i.full_brightness_ms) begin
      target = ipsm_pkg::ST_DIMSLEEP;
    end else if (idle >= cfg_i.light_sleep_ms) begin
      target = ipsm_pkg::ST_SLEEP;
    end else if (idle >= cfg_i.full_cpu_ms) begin
      target = ipsm_pkg::ST_DIM;
    end else begin
      target = ipsm_pkg::ST_RECENT;
    end
  end

  always_comb begin
    state_d    = state_q;
    last_d     = last_eff;
    poll_d[0]  = poll_eff[0];
    poll_d[1]  = poll_eff[1];
    mark_d     = mark_q;
    latch_d    = latch_q;
    changed    = 1'b0;
    shut       = 1'b0;
    sleep_req  = 1'b0;
    sleep_ok   = 1'b0;
    other_mark = 1'b0;
    if (item_i.func) begin
      last_d  = item_i.now_ms;
      latch_d = 1'b0;
    end else begin
      changed = (target != state_q);
      state_d = target;
      if (changed) begin
        mark_d = 2'b00;
        if (target == ipsm_pkg::ST_SHUTDOWN && !latch_q) begin
          latch_d = 1'b1;
          shut    = 1'b1;
        end
      end
      sleep_ok = !sleep_blk && cfg_i.light_sleep_enable &&
                 (target == ipsm_pkg::ST_SLEEP || target == ipsm_pkg::ST_DIMSLEEP);
      other_mark = mark_d[other];
      if (sleep_ok) begin
        mark_d[item_i.core] = 1'b1;
        if (other_mark && (age <= {{(ipsm_pkg::TimeW-ipsm_pkg::SyncW){1'b0}},
                                   cfg_i.sync_window_ms})) begin
          mark_d    = 2'b00;
          sleep_req = 1'b1;
        end
      end else begin
        mark_d = 2'b00;
      end
      poll_d[item_i.core] = item_i.now_ms;
    end
  end

  assign code = ipsm_pkg::encode_state(state_d);

  always_comb begin
    res_o.power_state      = code;
    res_o.state_moved      = changed;
    res_o.brightness_full  = (code <= ipsm_pkg::CODE_SLEEP);
    res_o.cpu_max          = (code <= ipsm_pkg::CODE_RECENT);
    res_o.init_pulse       = first;
    res_o.shutdown_request = shut;
    res_o.sleep_request    = sleep_req;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ipsm_pkg::ST_RECENT;
      last_q    <= '0;
      poll_q[0] <= '0;
      poll_q[1] <= '0;
      mark_q    <= 2'b00;
      init_q    <= 1'b0;
      latch_q   <= 1'b0;
    end else if (adv_i) begin
      state_q   <= state_d;
      last_q    <= last_d;
      poll_q[0] <= poll_d[0];
      poll_q[1] <= poll_d[1];
      mark_q    <= mark_d;
      init_q    <= 1'b1;
      latch_q   <= latch_d;
    end
  end

  `IPSM_ASSERT(a_shut_in_state, adv_i && res_o.shutdown_request |=> (state_q == ipsm_pkg::ST_SHUTDOWN) && latch_q, "shutdown request without shutdown state")
  `IPSM_ASSERT(a_sleep_clears, adv_i && res_o.sleep_request |=> mark_q == 2'b00, "ready marks kept after sleep request")
  `IPSM_ASSERT(a_act_unlatch, adv_i && item_i.func |=> !latch_q && init_q, "activity left shutdown latch set")

endmodule

`default_nettype wire

FILE: sv/inactivity_power_state_manager_top.sv
// Pipeline: an input transaction is held in the input register, then its result
//   in the result register, which presents it until it is taken.
// Throughput: one item per cycle while the output is not stalled; the state update
//   for an item settles combinationally between the input and result registers.
// Reset: asynchronous, active low; clears the pipeline, the power state (to
//   recently active), timestamps, ready marks and flags, and restores the
//   configuration defaults.
`default_nettype none

`include "inactivity_power_state_manager_top_defines.svh"

module inactivity_power_state_manager_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // core[0], now_ms[32:1], save_blocked[33], audio_busy[34], zero fill
  input  wire logic [39:0] s_axis_tdata,
  // func[0]
  input  wire logic [0:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // power_state[2:0], state_moved[3], brightness_full[4], cpu_max[5],
  // init_pulse[6], shutdown_request[7], sleep_request[8], zero fill
  output      logic [15:0] m_axis_tdata,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  ipsm_pkg::cfg_t    cfg;
  ipsm_pkg::item_t   item_q;
  ipsm_pkg::result_t res, res_q;
  logic              in_vld_q, out_vld_q;
  logic              in_fire, adv, out_free;

  assign cfg_ready_o = 1'b1;

  ipsm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i & cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.func         <= s_axis_tuser[0];
      item_q.core         <= s_axis_tdata[0];
      item_q.now_ms       <= s_axis_tdata[32:1];
      item_q.save_blocked <= s_axis_tdata[33];
      item_q.audio_busy   <= s_axis_tdata[34];
    end
  end

  ipsm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'd0, res_q.sleep_request, res_q.shutdown_request,
                          res_q.init_pulse, res_q.cpu_max, res_q.brightness_full,
                          res_q.state_moved, res_q.power_state};

  `IPSM_ASSERT(a_stall_holds_item, !s_axis_tready |-> in_vld_q && out_vld_q, "input stalled with free pipeline")
  `IPSM_ASSERT(a_adv_fills_out, adv |=> out_vld_q, "advanced item lost before result register")

endmodule

`default_nettype wire
